// ===== sv/bmpe_pkg.sv =====
// bmpe_pkg: types and constants shared by the binomial mod-prime engine.
// No dependencies.
package bmpe_pkg;

    localparam logic [29:0] PRIME   = 30'd1000000007;
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;
    localparam int          MM_LAT  = 4;
    localparam int          WR_AW   = 17;

    typedef enum logic
    {
        FUNC_QUOTIENT = 1'b0,
        FUNC_BINOMIAL = 1'b1
    } func_t;

    typedef enum logic
    {
        STATUS_OK  = 1'b0,
        STATUS_ERR = 1'b1
    } status_t;

    typedef struct packed
    {
        logic       func;
        logic [9:0] n;
        logic [9:0] r;
    } query_t;

    typedef struct packed
    {
        logic [29:0] value;
        logic        status;
    } result_t;

    typedef struct packed
    {
        logic       func;
        logic       err;
        logic [9:0] n;
        logic [9:0] r;
        logic [9:0] nr;
    } item_t;

    typedef struct packed
    {
        logic             fac_we;
        logic             inv_we;
        logic [WR_AW-1:0] addr;
        logic [29:0]      data;
    } tbl_wr_t;

    typedef enum logic [2:0]
    {
        BLD_INIT,
        BLD_FAC,
        BLD_PMUL,
        BLD_PSQR,
        BLD_INV,
        BLD_DONE
    } bld_state_t;

endpackage

// ===== sv/bmpe_mulmod.sv =====
// bmpe_mulmod: pipelined a*b mod PRIME with Barrett reduction.
// Depends on bmpe_pkg.
module bmpe_mulmod
    import bmpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [29:0] a,
    input  logic [29:0] b,
    output logic        out_valid,
    output logic [29:0] res
);

    logic [MM_LAT-1:0] valid_reg;
    logic [59:0]       prod_reg;
    logic [61:0]       t_reg;
    logic [31:0]       x2_reg;
    logic [59:0]       qp_reg;
    logic [31:0]       x3_reg;
    logic [29:0]       res_reg;
    logic [31:0]       diff;
    logic [31:0]       res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[MM_LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        diff = x3_reg - qp_reg[31:0];
        if (diff >= {1'b0, PRIME, 1'b0})
        begin
            res_next = diff - {1'b0, PRIME, 1'b0};
        end
        else if (diff >= {2'b0, PRIME})
        begin
            res_next = diff - {2'b0, PRIME};
        end
        else
        begin
            res_next = diff;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 60'(a) * 60'(b);
        t_reg    <= 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
        x2_reg   <= prod_reg[31:0];
        qp_reg   <= 60'(t_reg[60:31]) * 60'(PRIME);
        x3_reg   <= x2_reg;
        res_reg  <= res_next[29:0];
    end

    assign out_valid = valid_reg[MM_LAT-1];
    assign res       = res_reg;

endmodule

// ===== sv/bmpe_build.sv =====
// bmpe_build: post-reset sequencer writing the factorial and inverse tables.
// Depends on bmpe_pkg and bmpe_mulmod.
module bmpe_build
    import bmpe_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    output tbl_wr_t wr,
    output logic    done
);

    localparam int AW = $clog2(TABLE_SIZE);

    bld_state_t    state_reg, state_next;
    logic          busy_reg, busy_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [29:0]   acc_reg, acc_next;
    logic [29:0]   sq_reg, sq_next;
    logic [29:0]   exp_reg, exp_next;
    tbl_wr_t       wr_reg, wr_next;
    logic          done_reg, done_next;

    logic          mm_in_valid;
    logic [29:0]   mm_a;
    logic [29:0]   mm_b;
    logic          mm_out_valid;
    logic [29:0]   mm_res;

    bmpe_mulmod u_mulmod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm_in_valid),
        .a         (mm_a),
        .b         (mm_b),
        .out_valid (mm_out_valid),
        .res       (mm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_INIT;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            wr_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            wr_reg    <= wr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        done_next   = done_reg;
        wr_next     = '0;
        mm_in_valid = 1'b0;
        mm_a        = acc_reg;
        mm_b        = sq_reg;
        unique case (state_reg)
            BLD_INIT:
            begin
                wr_next.fac_we = 1'b1;
                wr_next.addr   = '0;
                wr_next.data   = 30'd1;
                acc_next       = 30'd1;
                idx_next       = AW'(1);
                busy_next      = 1'b0;
                state_next     = BLD_FAC;
            end
            BLD_FAC:
            begin
                mm_a = 30'(idx_reg);
                mm_b = acc_reg;
                if (!busy_reg)
                begin
                    mm_in_valid = 1'b1;
                    busy_next   = 1'b1;
                end
                else if (mm_out_valid)
                begin
                    busy_next      = 1'b0;
                    acc_next       = mm_res;
                    wr_next.fac_we = 1'b1;
                    wr_next.addr   = WR_AW'(idx_reg);
                    wr_next.data   = mm_res;
                    if (idx_reg == AW'(TABLE_SIZE - 1))
                    begin
                        sq_next    = mm_res;
                        acc_next   = 30'd1;
                        exp_next   = PRIME - 30'd2;
                        state_next = BLD_PMUL;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            BLD_PMUL:
            begin
                if (!exp_reg[0])
                begin
                    state_next = BLD_PSQR;
                end
                else if (!busy_reg)
                begin
                    mm_in_valid = 1'b1;
                    busy_next   = 1'b1;
                end
                else if (mm_out_valid)
                begin
                    busy_next  = 1'b0;
                    acc_next   = mm_res;
                    state_next = BLD_PSQR;
                end
            end
            BLD_PSQR:
            begin
                mm_a = sq_reg;
                if (!busy_reg)
                begin
                    mm_in_valid = 1'b1;
                    busy_next   = 1'b1;
                end
                else if (mm_out_valid)
                begin
                    busy_next = 1'b0;
                    sq_next   = mm_res;
                    exp_next  = exp_reg >> 1;
                    if (exp_reg[29:1] == '0)
                    begin
                        wr_next.inv_we = 1'b1;
                        wr_next.addr   = WR_AW'(TABLE_SIZE - 1);
                        wr_next.data   = acc_reg;
                        idx_next       = AW'(TABLE_SIZE - 1);
                        state_next     = BLD_INV;
                    end
                    else
                    begin
                        state_next = BLD_PMUL;
                    end
                end
            end
            BLD_INV:
            begin
                mm_b = 30'(idx_reg);
                if (!busy_reg)
                begin
                    mm_in_valid = 1'b1;
                    busy_next   = 1'b1;
                end
                else if (mm_out_valid)
                begin
                    busy_next      = 1'b0;
                    acc_next       = mm_res;
                    wr_next.inv_we = 1'b1;
                    wr_next.addr   = WR_AW'(idx_reg - AW'(1));
                    wr_next.data   = mm_res;
                    idx_next       = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = BLD_DONE;
                    end
                end
            end
            BLD_DONE:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                state_next = BLD_INIT;
            end
        endcase
    end

    assign wr   = wr_reg;
    assign done = done_reg;

endmodule

// ===== sv/bmpe_front.sv =====
// bmpe_front: accepts queries, classifies errors, queues them for the back end.
// Depends on bmpe_pkg.
module bmpe_front
    import bmpe_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   tables_ready,
    input  logic   query_valid,
    output logic   query_ready,
    input  query_t query,
    output logic   item_valid,
    output item_t  item,
    input  logic   item_pop
);

    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);

    item_t          q_mem [QD];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           push;
    item_t          cls;

    assign query_ready = tables_ready && (cnt_reg < (QAW+1)'(QD));
    assign push        = query_valid && query_ready;

    always_comb
    begin
        cls.func = query.func;
        cls.n    = query.n;
        cls.r    = query.r;
        cls.nr   = query.n - query.r;
        cls.err  = (32'(query.n) >= 32'(TABLE_SIZE)) || (32'(query.r) >= 32'(TABLE_SIZE))
                   || ((query.func == FUNC_BINOMIAL) && (query.r > query.n));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + QAW'(1);
            end
            if (item_pop)
            begin
                rp_reg <= rp_reg + QAW'(1);
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(item_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= cls;
        end
    end

    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem[rp_reg];

endmodule

// ===== sv/bmpe_back.sv =====
// bmpe_back: table memories, query multiply pipeline and result FIFO.
// Depends on bmpe_pkg and bmpe_mulmod.
module bmpe_back
    import bmpe_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  tbl_wr_t wr,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int OD  = 16;
    localparam int OAW = $clog2(OD);

    logic [29:0] fac_mem [TABLE_SIZE];
    logic [29:0] inv_mem [TABLE_SIZE];

    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic        s1_err_reg;
    logic [29:0] fac_rd_reg;
    logic [29:0] invr_rd_reg;
    logic [29:0] invnr_rd_reg;

    logic        d1_func [MM_LAT];
    logic        d1_err  [MM_LAT];
    logic [29:0] d1_inv  [MM_LAT];
    logic        d2_err  [MM_LAT];

    logic        mm1_valid, mm2_valid;
    logic [29:0] mm1_res, mm2_res;
    logic [29:0] mm2_b;

    result_t        o_mem [OD];
    logic [OAW-1:0] owp_reg, orp_reg;
    logic [OAW:0]   ocnt_reg;
    logic [OAW:0]   occ_reg;
    logic           out_pop;
    result_t        push_data;

    assign item_pop = item_valid && (occ_reg < (OAW+1)'(OD));
    assign out_pop  = result_valid && result_ready;

    always_ff @(posedge clk)
    begin
        if (wr.fac_we)
        begin
            fac_mem[AW'(wr.addr)] <= wr.data;
        end
        if (wr.inv_we)
        begin
            inv_mem[AW'(wr.addr)] <= wr.data;
        end
        fac_rd_reg   <= fac_mem[AW'(item.n)];
        invr_rd_reg  <= inv_mem[AW'(item.r)];
        invnr_rd_reg <= inv_mem[AW'(item.nr)];
        s1_func_reg  <= item.func;
        s1_err_reg   <= item.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_pop;
        end
    end

    bmpe_mulmod u_mm1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .a         (fac_rd_reg),
        .b         (invr_rd_reg),
        .out_valid (mm1_valid),
        .res       (mm1_res)
    );

    always_ff @(posedge clk)
    begin
        d1_func[0] <= s1_func_reg;
        d1_err[0]  <= s1_err_reg;
        d1_inv[0]  <= invnr_rd_reg;
        d2_err[0]  <= d1_err[MM_LAT-1];
        for (int k = 1; k < MM_LAT; k++)
        begin
            d1_func[k] <= d1_func[k-1];
            d1_err[k]  <= d1_err[k-1];
            d1_inv[k]  <= d1_inv[k-1];
            d2_err[k]  <= d2_err[k-1];
        end
    end

    assign mm2_b = (d1_func[MM_LAT-1] == FUNC_BINOMIAL) ? d1_inv[MM_LAT-1] : 30'd1;

    bmpe_mulmod u_mm2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm1_valid),
        .a         (mm1_res),
        .b         (mm2_b),
        .out_valid (mm2_valid),
        .res       (mm2_res)
    );

    always_comb
    begin
        push_data.value  = d2_err[MM_LAT-1] ? 30'd0 : mm2_res;
        push_data.status = d2_err[MM_LAT-1] ? STATUS_ERR : STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (mm2_valid)
        begin
            o_mem[owp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            if (mm2_valid)
            begin
                owp_reg <= owp_reg + OAW'(1);
            end
            if (out_pop)
            begin
                orp_reg <= orp_reg + OAW'(1);
            end
            ocnt_reg <= ocnt_reg + (OAW+1)'(mm2_valid) - (OAW+1)'(out_pop);
            occ_reg  <= occ_reg + (OAW+1)'(item_pop) - (OAW+1)'(out_pop);
        end
    end

    assign result_valid = (ocnt_reg != '0);
    assign result       = o_mem[orp_reg];

endmodule

// ===== sv/binomial_mod_prime_engine.sv =====
// binomial_mod_prime_engine: n!/r! and C(n,r) modulo 1000000007 from built tables.
// One query per cycle sustained while tables are ready and result_ready keeps the result FIFO drained.
// Result rate is set by two 4-stage Barrett multiply pipelines and a 16-entry result FIFO.
// After reset (rst_n, asynchronous, active low) a single multiply pipeline builds the
// tables; query_ready stays low until they are built.
module binomial_mod_prime_engine
    import bmpe_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_ready,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    tbl_wr_t wr;
    logic    tables_ready;
    logic    item_valid;
    item_t   item;
    logic    item_pop;

    bmpe_build #(.TABLE_SIZE(TABLE_SIZE)) u_build
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .done  (tables_ready)
    );

    bmpe_front #(.TABLE_SIZE(TABLE_SIZE)) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tables_ready (tables_ready),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    bmpe_back #(.TABLE_SIZE(TABLE_SIZE)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
